// File: rtl/core/ir_constant_folder_assert.svh
// ----------------------------------------------------------------------------
// ir_constant_folder_assert.svh
// Assertion macros for the constant folder RTL.
// ----------------------------------------------------------------------------
`ifndef IR_CONSTANT_FOLDER_ASSERT_SVH
`define IR_CONSTANT_FOLDER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("constant folder assertion failed");
// next-cycle implication
`define CF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("constant folder assertion failed");
`else
`define CF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/ir_cf_pkg.sv
// ----------------------------------------------------------------------------
// ir_cf_pkg
// Types and constants shared by the constant folder files.
// ----------------------------------------------------------------------------
package ir_cf_pkg;

   localparam int WORD_W = 64;
   localparam int REG_W  = 8;
   localparam int OP_W   = 5;
   localparam int CNT_W  = 6;

   typedef enum logic [OP_W-1:0] {
      OP_IMM   = 5'd0,
      OP_ADD   = 5'd1,
      OP_SUB   = 5'd2,
      OP_MUL   = 5'd3,
      OP_DIV   = 5'd4,
      OP_MOD   = 5'd5,
      OP_AND   = 5'd6,
      OP_OR    = 5'd7,
      OP_XOR   = 5'd8,
      OP_SHL   = 5'd9,
      OP_SHR   = 5'd10,
      OP_EQ    = 5'd11,
      OP_NE    = 5'd12,
      OP_LT    = 5'd13,
      OP_LE    = 5'd14,
      OP_GT    = 5'd15,
      OP_GE    = 5'd16,
      OP_OTHER = 5'd17
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_L,
      ST_RD_R,
      ST_LOAD_B,
      ST_EXEC,
      ST_MAG_A,
      ST_MAG_B,
      ST_DIV_LOOP,
      ST_DIV_FIX,
      ST_MUL_LOOP,
      ST_FINISH
   } state_type;

   // binary ops that can fold when both sources are known
   function automatic logic is_foldable(logic [OP_W-1:0] op);
      return (op >= OP_ADD) && (op <= OP_GE);
   endfunction

endpackage

// File: rtl/core/ir_cf_ram.sv
// ----------------------------------------------------------------------------
// ir_cf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ir_cf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/core/ir_constant_folder.sv
// ----------------------------------------------------------------------------
// ir_constant_folder
// Constant folding over a stream of IR instructions, one beat per instruction.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  instruction fields
//   rsp_      out        rsp_valid / rsp_stall  rewritten, dest_known, const_value
//
// An immediate load or a beat without two known sources goes straight to
// finish; add/sub/logic/shift/compare read both sources and execute once;
// mul and div/mod step one 64-bit adder, shared by arithmetic and compare,
// one bit per cycle (div/mod skip to finish when the divisor is zero).
// Reset clears the known flags at once; no clearing pass follows.
// A result held by rsp_stall waits in the output register; the next
// beat is taken meanwhile and parks in its last state until the slot frees.
//
module ir_constant_folder #(
   parameter int VREG_COUNT = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_new_function,
   input  logic [ir_cf_pkg::OP_W-1:0]          req_opcode,
   input  logic                                req_has_dest,
   input  logic [ir_cf_pkg::REG_W-1:0]         req_dest_reg,
   input  logic                                req_has_left,
   input  logic [ir_cf_pkg::REG_W-1:0]         req_left_reg,
   input  logic                                req_has_right,
   input  logic [ir_cf_pkg::REG_W-1:0]         req_right_reg,
   input  logic signed [ir_cf_pkg::WORD_W-1:0] req_immediate,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_rewritten,
   output logic                                rsp_dest_known,
   output logic signed [ir_cf_pkg::WORD_W-1:0] rsp_const_value
);

   import ir_cf_pkg::*;

   `include "ir_constant_folder_assert.svh"

   // only 256 registers are nameable with 8-bit fields
   localparam int DEPTH = (VREG_COUNT < (1 << REG_W)) ? VREG_COUNT : (1 << REG_W);
   localparam int IDX_W = $clog2(DEPTH);

   state_type             state_ff, state_in;
   logic [DEPTH-1:0]      flags_ff;
   logic [OP_W-1:0]       op_ff;
   logic                  dest_ok_ff;
   logic [IDX_W-1:0]      dst_idx_ff, left_idx_ff, right_idx_ff;
   logic [WORD_W-1:0]     imm_ff, a_ff, b_ff, res_ff;
   logic                  fold_ff, neg_q_ff, neg_r_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  rsp_valid_ff, rsp_rewritten_ff, rsp_known_ff;
   logic [WORD_W-1:0]     rsp_value_ff;

   logic                  accept, out_free, left_known, right_known, start_fold;
   logic                  dest_in_range, left_in_range, right_in_range;
   logic                  record, last_step, rdata_zero;
   logic [WORD_W-1:0]     rec_value, ram_rdata, div_t, fix_v, exec_res;
   logic [WORD_W-1:0]     add_x, add_y;
   logic                  add_sub;
   logic [WORD_W:0]       sum;
   logic [IDX_W-1:0]      ram_raddr;
   logic                  lt, eq;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (cnt_ff == {CNT_W{1'b1}});
   assign rdata_zero = (ram_rdata == '0);

   // range checks against the configured table size
   assign dest_in_range  = (32'(req_dest_reg) < 32'(VREG_COUNT));
   assign left_in_range  = (32'(req_left_reg) < 32'(VREG_COUNT));
   assign right_in_range = (32'(req_right_reg) < 32'(VREG_COUNT));

   // a new function wipes the flags before this beat looks at them
   assign left_known  = req_has_left && left_in_range && !req_new_function &&
                        flags_ff[req_left_reg[IDX_W-1:0]];
   assign right_known = req_has_right && right_in_range && !req_new_function &&
                        flags_ff[req_right_reg[IDX_W-1:0]];
   assign start_fold  = left_known && right_known && is_foldable(req_opcode);

   assign record    = dest_ok_ff && ((op_ff == OP_IMM) || fold_ff);
   assign rec_value = (op_ff == OP_IMM) ? imm_ff : res_ff;

   // values table: read left then right, write at finish
   assign ram_raddr = (state_ff == ST_RD_L) ? left_idx_ff : right_idx_ff;

   ir_cf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_values (
      .clock   (clock),
      .wr_en   ((state_ff == ST_FINISH) && out_free && record),
      .wr_addr (dst_idx_ff),
      .wr_data (rec_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = start_fold ? ST_RD_L : ST_FINISH;
            end
         end
         ST_RD_L:   state_in = ST_RD_R;
         ST_RD_R:   state_in = ST_LOAD_B;
         ST_LOAD_B: begin
            priority if (op_ff == OP_MUL) begin
               state_in = ST_MUL_LOOP;
            end else if ((op_ff == OP_DIV) || (op_ff == OP_MOD)) begin
               state_in = rdata_zero ? ST_FINISH : ST_MAG_A;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC:     state_in = ST_FINISH;
         ST_MAG_A:    state_in = ST_MAG_B;
         ST_MAG_B:    state_in = ST_DIV_LOOP;
         ST_DIV_LOOP: state_in = last_step ? ST_DIV_FIX : ST_DIV_LOOP;
         ST_DIV_FIX:  state_in = ST_FINISH;
         ST_MUL_LOOP: state_in = last_step ? ST_FINISH : ST_MUL_LOOP;
         ST_FINISH:   state_in = out_free ? ST_IDLE : ST_FINISH;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Shared adder steering
   // ---------------------------------------------------------------------
   assign div_t = {res_ff[WORD_W-2:0], a_ff[WORD_W-1]};
   assign fix_v = (op_ff == OP_DIV) ? a_ff : res_ff;

   always_comb begin
      add_x   = a_ff;
      add_y   = b_ff;
      add_sub = 1'b1;
      unique case (state_ff)
         ST_EXEC:     add_sub = (op_ff != OP_ADD);
         ST_MAG_A: begin
            add_x = '0;
            add_y = a_ff;
         end
         ST_MAG_B: begin
            add_x = '0;
            add_y = b_ff;
         end
         ST_DIV_LOOP: add_x = div_t;
         ST_DIV_FIX: begin
            add_x = '0;
            add_y = fix_v;
         end
         ST_MUL_LOOP: begin
            add_x   = res_ff;
            add_y   = b_ff[0] ? a_ff : '0;
            add_sub = 1'b0;
         end
         default: begin
            add_x   = a_ff;
            add_y   = b_ff;
            add_sub = 1'b1;
         end
      endcase
   end

   // carry out of a subtract means x >= y (no borrow)
   assign sum = {1'b0, add_x} + {1'b0, add_y ^ {WORD_W{add_sub}}} +
                {{WORD_W{1'b0}}, add_sub};

   // signed compare from the subtract
   assign eq = (a_ff == b_ff);
   assign lt = (a_ff[WORD_W-1] != b_ff[WORD_W-1]) ? a_ff[WORD_W-1] : sum[WORD_W-1];

   always_comb begin
      unique case (op_ff)
         OP_ADD, OP_SUB: exec_res = sum[WORD_W-1:0];
         OP_AND:  exec_res = a_ff & b_ff;
         OP_OR:   exec_res = a_ff | b_ff;
         OP_XOR:  exec_res = a_ff ^ b_ff;
         OP_SHL:  exec_res = a_ff << b_ff[5:0];
         OP_SHR:  exec_res = WORD_W'($signed(a_ff) >>> b_ff[5:0]);
         OP_EQ:   exec_res = {{(WORD_W-1){1'b0}}, eq};
         OP_NE:   exec_res = {{(WORD_W-1){1'b0}}, !eq};
         OP_LT:   exec_res = {{(WORD_W-1){1'b0}}, lt};
         OP_LE:   exec_res = {{(WORD_W-1){1'b0}}, lt || eq};
         OP_GT:   exec_res = {{(WORD_W-1){1'b0}}, !lt && !eq};
         OP_GE:   exec_res = {{(WORD_W-1){1'b0}}, !lt};
         default: exec_res = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && req_new_function) begin
            flags_ff <= '0;
         end
         if ((state_ff == ST_FINISH) && out_free) begin
            // overwrite the destination flag: set if recorded, drop otherwise
            if (dest_ok_ff) begin
               flags_ff[dst_idx_ff] <= record;
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_ff        <= req_opcode;
               dest_ok_ff   <= req_has_dest && dest_in_range;
               dst_idx_ff   <= req_dest_reg[IDX_W-1:0];
               left_idx_ff  <= req_left_reg[IDX_W-1:0];
               right_idx_ff <= req_right_reg[IDX_W-1:0];
               imm_ff       <= req_immediate;
               fold_ff      <= 1'b0;
               cnt_ff       <= '0;
            end
         end
         ST_RD_R: a_ff <= ram_rdata;
         ST_LOAD_B: begin
            b_ff     <= ram_rdata;
            neg_q_ff <= a_ff[WORD_W-1] ^ ram_rdata[WORD_W-1];
            neg_r_ff <= a_ff[WORD_W-1];
            res_ff   <= '0;
         end
         ST_EXEC: begin
            res_ff  <= exec_res;
            fold_ff <= 1'b1;
         end
         ST_MAG_A: begin
            if (a_ff[WORD_W-1]) begin
               a_ff <= sum[WORD_W-1:0];
            end
         end
         ST_MAG_B: begin
            if (b_ff[WORD_W-1]) begin
               b_ff <= sum[WORD_W-1:0];
            end
            res_ff <= '0;
         end
         ST_DIV_LOOP: begin
            // restoring step: remainder in res_ff, quotient shifts into a_ff
            res_ff <= sum[WORD_W] ? sum[WORD_W-1:0] : div_t;
            a_ff   <= {a_ff[WORD_W-2:0], sum[WORD_W]};
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_DIV_FIX: begin
            res_ff  <= ((op_ff == OP_DIV) ? neg_q_ff : neg_r_ff) ?
                       sum[WORD_W-1:0] : fix_v;
            fold_ff <= 1'b1;
         end
         ST_MUL_LOOP: begin
            res_ff <= sum[WORD_W-1:0];
            a_ff   <= {a_ff[WORD_W-2:0], 1'b0};
            b_ff   <= {1'b0, b_ff[WORD_W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               fold_ff <= 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_rewritten_ff <= record && (op_ff != OP_IMM);
               rsp_known_ff     <= record;
               rsp_value_ff     <= record ? rec_value : '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rewritten   = rsp_rewritten_ff;
   assign rsp_dest_known  = rsp_known_ff;
   assign rsp_const_value = rsp_value_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `CF_ASSERT_NEXT(a_finish_emits, clock, reset, (state_ff == ST_FINISH) && out_free, rsp_valid)
   `CF_ASSERT_IMPL(a_rewrite_known, clock, reset, rsp_valid && rsp_rewritten, rsp_dest_known)
   `CF_ASSERT_IMPL(a_div_nonzero, clock, reset, state_ff == ST_DIV_LOOP, b_ff != '0)
   `CF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

endmodule
